@@ design/rc_vehicle_drive_controller_defines.svh @@
// ----------------------------------------------------------------------------
// RC vehicle drive controller: assertion macros
// Shared assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef RC_VEHICLE_DRIVE_CONTROLLER_DEFINES_SVH
`define RC_VEHICLE_DRIVE_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
// Implication check on the rising clock, held off during reset.
`define RCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcd assertion failed");
// Next-cycle implication check.
`define RCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcd assertion failed");
// Plain invariant.
`define RCD_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rcd assertion failed");
`else
`define RCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define RCD_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`endif
`endif

@@ design/rcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_pkg
// Types and constants shared by the drive controller modules.
// ----------------------------------------------------------------------------
package rcd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic div_step;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_hold;
  } stat_t;

  typedef struct packed {
    logic [1:0]  steer_mode;
    logic [11:0] center_position;
    logic [11:0] left_position;
    logic [11:0] right_position;
  } cfg_t;

  localparam logic [1:0] MODE_PULSE    = 2'd0;
  localparam logic [1:0] MODE_FEEDBACK = 2'd1;
  localparam logic [1:0] MODE_OPEN     = 2'd2;

  localparam logic [1:0] REG_STEER_MODE = 2'd0;
  localparam logic [1:0] REG_CENTER     = 2'd1;
  localparam logic [1:0] REG_LEFT       = 2'd2;
  localparam logic [1:0] REG_RIGHT      = 2'd3;

  localparam logic [1:0]  RST_STEER_MODE = MODE_PULSE;
  localparam logic [11:0] RST_CENTER     = 12'd2048;
  localparam logic [11:0] RST_LEFT       = 12'd1024;
  localparam logic [11:0] RST_RIGHT      = 12'd3072;

  localparam int unsigned BTN_FRONT     = 0;
  localparam int unsigned BTN_AUX       = 3;
  localparam int unsigned BTN_GEAR_DOWN = 4;
  localparam int unsigned BTN_GEAR_UP   = 5;

  localparam logic [3:0] HAT_UP   = 4'd0;
  localparam logic [3:0] HAT_DOWN = 4'd4;

  localparam logic signed [3:0] GEAR_RESET   = 4'sd1;
  localparam logic signed [3:0] GEAR_TOP     = 4'sd4;
  localparam logic signed [3:0] GEAR_REVERSE = -4'sd1;

  localparam logic [11:0] PULSE_MIN      = 12'd512;
  localparam logic [11:0] CENTER_TOL     = 12'd192;
  localparam logic [11:0] SIDE_TOL       = 12'd96;
  localparam logic [11:0] DEFAULT_TOL    = 12'd160;
  localparam logic [7:0]  TRIG_DEADZONE  = 8'd12;
  localparam logic [8:0]  LEVEL_LOW      = 9'd64;
  localparam logic [8:0]  LEVEL_HIGH     = 9'd256;
  localparam logic [8:0]  POWER_CENTER   = 9'd192;
  localparam logic [7:0]  CENTER_SETTLE  = 8'd10;

  localparam int unsigned DIV_STEPS = 25;

  function automatic logic [1:0] next_level(input logic [1:0] lv);
    logic [1:0] res;
    case (lv)
      2'd0:    res = 2'd1;
      2'd1:    res = 2'd2;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

  function automatic logic [8:0] intensity(input logic [1:0] lv);
    logic [8:0] res;
    case (lv)
      2'd0:    res = 9'd0;
      2'd2:    res = LEVEL_HIGH;
      default: res = LEVEL_LOW;
    endcase
    return res;
  endfunction

  function automatic logic [11:0] absdiff(input logic [11:0] a, input logic [11:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

@@ design/rcd_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_in_if
// Gamepad tick channel: one word per control tick.
// ----------------------------------------------------------------------------
interface rcd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] buttons_held;
  logic [15:0] buttons_changed;
  logic [3:0]  hat_direction;
  logic [7:0]  stick_x;
  logic [7:0]  brake_trigger;
  logic [7:0]  throttle_trigger;
  logic [11:0] feedback_sample;

  modport source (
    output valid, buttons_held, buttons_changed, hat_direction, stick_x,
           brake_trigger, throttle_trigger, feedback_sample,
    input  ready
  );
  modport sink (
    input  valid, buttons_held, buttons_changed, hat_direction, stick_x,
           brake_trigger, throttle_trigger, feedback_sample,
    output ready
  );
endinterface

@@ design/rcd_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_out_if
// PWM level channel: one word per control tick.
// ----------------------------------------------------------------------------
interface rcd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] servo_level_a;
  logic [11:0] servo_level_b;
  logic [8:0]  servo_drive;
  logic [8:0]  motor_forward;
  logic [8:0]  motor_reverse;
  logic [8:0]  front_light;
  logic [8:0]  tail_light;
  logic [8:0]  aux_light;

  modport source (
    output valid, servo_level_a, servo_level_b, servo_drive, motor_forward,
           motor_reverse, front_light, tail_light, aux_light,
    input  ready
  );
  modport sink (
    input  valid, servo_level_a, servo_level_b, servo_drive, motor_forward,
           motor_reverse, front_light, tail_light, aux_light,
    output ready
  );
endinterface

@@ design/rcd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_ctrl
// Sequencer for one tick: latch, evaluate, divide, interpolate, emit.
// ----------------------------------------------------------------------------
module rcd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rcd_pkg::stat_t stat,
  output rcd_pkg::cmd_t  cmd
);

  rcd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      rcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rcd_pkg::ST_CALC;
        end
      end
      rcd_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = stat.need_div ? rcd_pkg::ST_DIV : rcd_pkg::ST_MUL;
      end
      rcd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = rcd_pkg::ST_MUL;
        end
      end
      rcd_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = rcd_pkg::ST_EMIT;
      end
      rcd_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!stat.out_hold) begin
          cmd.emit  = 1'b1;
          state_nxt = rcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rcd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/rcd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_dp
// Tick datapath: vehicle state, steering target, divider, output register.
// ----------------------------------------------------------------------------
module rcd_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  rcd_pkg::cfg_t  cfg,
  input  rcd_pkg::cmd_t  cmd,
  output rcd_pkg::stat_t stat,
  input  logic [15:0]    in_buttons_held,
  input  logic [15:0]    in_buttons_changed,
  input  logic [3:0]     in_hat_direction,
  input  logic [7:0]     in_stick_x,
  input  logic [7:0]     in_brake_trigger,
  input  logic [7:0]     in_throttle_trigger,
  input  logic [11:0]    in_feedback_sample,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [11:0]    out_servo_level_a,
  output logic [11:0]    out_servo_level_b,
  output logic [8:0]     out_servo_drive,
  output logic [8:0]     out_motor_forward,
  output logic [8:0]     out_motor_reverse,
  output logic [8:0]     out_front_light,
  output logic [8:0]     out_tail_light,
  output logic [8:0]     out_aux_light
);

  // latched tick
  logic [15:0] press_r;
  logic [3:0]  hat_r;
  logic [7:0]  lx_r, l2_r, r2_r;
  logic [11:0] cur_r;

  // vehicle state
  logic [1:0]        front_r, aux_r;
  logic signed [3:0] gear_r;
  logic [7:0]        ticks_r;

  // steering work registers
  logic        c_ok_r, l_ok_r, r_ok_r;
  logic [11:0] pos0_r, pos1_r, den_r, rem_r, tgt_r;
  logic [24:0] quo_r;
  logic        neg_r;
  logic [4:0]  cnt_r;
  logic        out_valid_r;

  // ---- evaluation ----
  logic [1:0]        front_nxt, aux_nxt;
  logic signed [3:0] gear_nxt;
  logic [7:0]        wa, wb;
  logic [11:0]       pb;
  logic [19:0]       tsum;
  logic [11:0]       tgt, dc, dl, dr;
  logic              c_ok, l_ok, r_ok, interp, need_div;
  logic signed [13:0] range_s, num_s;
  logic [12:0]       num_abs;
  logic [11:0]       sel;

  always_comb begin
    front_nxt = press_r[rcd_pkg::BTN_FRONT] ? rcd_pkg::next_level(front_r) : front_r;
    aux_nxt   = press_r[rcd_pkg::BTN_AUX] ? rcd_pkg::next_level(aux_r) : aux_r;
    gear_nxt  = gear_r;
    if (press_r[rcd_pkg::BTN_GEAR_DOWN] && gear_nxt > 4'sd0) begin
      gear_nxt = gear_nxt - 4'sd1;
    end
    if (press_r[rcd_pkg::BTN_GEAR_UP] && gear_nxt >= 4'sd0 && gear_nxt < rcd_pkg::GEAR_TOP) begin
      gear_nxt = gear_nxt + 4'sd1;
    end
    if (hat_r == rcd_pkg::HAT_UP) begin
      gear_nxt = rcd_pkg::GEAR_RESET;
    end else if (hat_r == rcd_pkg::HAT_DOWN) begin
      gear_nxt = rcd_pkg::GEAR_REVERSE;
    end

    // stick onto calibrated positions
    if (!lx_r[7]) begin
      wa = lx_r;
      wb = 8'd128 - lx_r;
      pb = cfg.left_position;
    end else begin
      wa = 8'd255 - lx_r;
      wb = lx_r - 8'd127;
      pb = cfg.right_position;
    end
    tsum = 20'(cfg.center_position * wa) + 20'(pb * wb);
    tgt  = tsum[18:7];
    dc   = rcd_pkg::absdiff(tgt, cfg.center_position);
    dl   = rcd_pkg::absdiff(tgt, cfg.left_position);
    dr   = rcd_pkg::absdiff(tgt, cfg.right_position);
    c_ok = dc < rcd_pkg::CENTER_TOL;
    l_ok = dl < rcd_pkg::SIDE_TOL;
    r_ok = dr < rcd_pkg::SIDE_TOL;

    interp  = 1'b0;
    range_s = '0;
    num_s   = '0;
    sel     = tgt;
    if (c_ok) begin
      sel = cfg.center_position;
    end else if (l_ok) begin
      sel = cfg.left_position;
    end else if (r_ok) begin
      sel = cfg.right_position;
    end else if (dl < dr) begin
      interp  = 1'b1;
      range_s = $signed({2'b00, cfg.center_position}) - $signed({2'b00, cfg.left_position})
                - 14'sd96;
      num_s   = $signed({2'b00, tgt}) - $signed({2'b00, cfg.left_position}) + 14'sd96;
    end else begin
      interp  = 1'b1;
      range_s = $signed({2'b00, cfg.right_position}) - $signed({2'b00, cfg.center_position})
                - 14'sd288;
      num_s   = $signed({2'b00, tgt}) - $signed({2'b00, cfg.center_position}) - 14'sd192;
    end
    num_abs  = num_s[13] ? 13'(-num_s) : num_s[12:0];
    need_div = (cfg.steer_mode == rcd_pkg::MODE_FEEDBACK) && interp && (range_s > 14'sd0);
  end

  // ---- restoring divider step ----
  logic [12:0] div_sh, div_sub;
  logic        div_bit;
  always_comb begin
    div_sh  = {rem_r, quo_r[24]};
    div_sub = div_sh - {1'b0, den_r};
    div_bit = div_sh >= {1'b0, den_r};
  end

  // ---- interpolation multiply ----
  logic signed [25:0] w_s;
  logic signed [12:0] d_s;
  logic signed [38:0] prod_s;
  logic signed [39:0] r_s;
  logic [11:0]        tgt_fin;
  always_comb begin
    w_s    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    d_s    = $signed({1'b0, pos1_r}) - $signed({1'b0, pos0_r});
    prod_s = 39'(d_s * w_s);
    r_s    = $signed({16'd0, pos0_r, 12'd0}) + 40'(prod_s);
    if (r_s < 40'sd0) begin
      tgt_fin = '0;
    end else if (r_s[39:24] != 16'd0) begin
      tgt_fin = 12'd4095;
    end else begin
      tgt_fin = r_s[23:12];
    end
  end

  // ---- result assembly ----
  logic [11:0] sa, sb, diff;
  logic [8:0]  power, fwd, rev, speed, amt;
  logic [7:0]  dev;
  logic [2:0]  gabs;
  logic        brake;
  always_comb begin
    sa    = '0;
    sb    = '0;
    power = '0;
    diff  = rcd_pkg::absdiff(tgt_r, cur_r);
    gabs  = gear_r[3] ? 3'(-gear_r) : gear_r[2:0];
    dev   = (lx_r <= 8'd128) ? 8'd128 - lx_r : lx_r - 8'd127;
    amt   = {dev, 1'b0};
    if (amt < 9'(rcd_pkg::TRIG_DEADZONE)) begin
      amt = '0;
    end
    case (cfg.steer_mode)
      rcd_pkg::MODE_PULSE: begin
        sa = rcd_pkg::PULSE_MIN + {1'b0, lx_r, 3'b000};
        sb = rcd_pkg::PULSE_MIN + {gabs, 9'd0};
      end
      rcd_pkg::MODE_FEEDBACK: begin
        power = 9'(diff[11:6]) + rcd_pkg::POWER_CENTER;
        if (l_ok_r || r_ok_r) begin
          power = rcd_pkg::LEVEL_HIGH;
        end else if (c_ok_r) begin
          power = rcd_pkg::POWER_CENTER;
        end
        if (diff < rcd_pkg::DEFAULT_TOL) begin
          power = '0;
        end
        if (c_ok_r && ticks_r >= rcd_pkg::CENTER_SETTLE) begin
          sa = '0;
        end else if (cur_r < tgt_r || r_ok_r) begin
          sa = 12'd256;
        end else begin
          sb = 12'd256;
        end
      end
      default: begin
        power = rcd_pkg::LEVEL_HIGH;
        if (lx_r <= 8'd128) begin
          sb = {3'd0, amt};
        end else begin
          sa = {3'd0, amt};
        end
      end
    endcase

    brake = l2_r >= rcd_pkg::TRIG_DEADZONE;
    speed = {1'b0, brake ? l2_r : r2_r} + 9'd1;
    if (speed < 9'(rcd_pkg::TRIG_DEADZONE)) begin
      speed = '0;
    end
    if (brake) begin
      fwd = speed;
      rev = speed;
    end else if (gear_r < 4'sd0) begin
      fwd = '0;
      rev = speed;
    end else begin
      fwd = speed;
      rev = '0;
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      aux_r       <= '0;
      gear_r      <= rcd_pkg::GEAR_RESET;
      ticks_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.calc) begin
        front_r <= front_nxt;
        aux_r   <= aux_nxt;
        gear_r  <= gear_nxt;
        if (cfg.steer_mode == rcd_pkg::MODE_FEEDBACK) begin
          if (!c_ok) begin
            ticks_r <= '0;
          end else if (ticks_r != 8'd255) begin
            ticks_r <= ticks_r + 8'd1;
          end
        end
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 5'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      press_r <= in_buttons_held & in_buttons_changed;
      hat_r   <= in_hat_direction;
      lx_r    <= in_stick_x;
      l2_r    <= in_brake_trigger;
      r2_r    <= in_throttle_trigger;
      cur_r   <= in_feedback_sample;
    end
    if (cmd.calc) begin
      c_ok_r <= c_ok;
      l_ok_r <= l_ok;
      r_ok_r <= r_ok;
      rem_r  <= '0;
      den_r  <= range_s[11:0];
      if (need_div) begin
        pos0_r <= interp && (dl < dr) ? cfg.left_position : cfg.center_position;
        pos1_r <= interp && (dl < dr) ? cfg.center_position : cfg.right_position;
        quo_r  <= {num_abs[12:0], 12'd0};
        neg_r  <= num_s[13];
      end else begin
        // no division (no interpolation, other mode or degenerate range): weight 0 at pos0
        pos0_r <= (interp && (dl < dr)) ? cfg.left_position :
                  (interp ? cfg.center_position : sel);
        pos1_r <= sel;
        quo_r  <= '0;
        neg_r  <= 1'b0;
      end
    end else if (cmd.div_step) begin
      if (div_bit) begin
        rem_r <= div_sub[11:0];
      end else begin
        rem_r <= div_sh[11:0];
      end
      quo_r <= {quo_r[23:0], div_bit};
    end
    if (cmd.mul) begin
      tgt_r <= tgt_fin;
    end
    if (cmd.emit) begin
      out_servo_level_a <= sa;
      out_servo_level_b <= sb;
      out_servo_drive   <= power;
      out_motor_forward <= fwd;
      out_motor_reverse <= rev;
      out_front_light   <= rcd_pkg::intensity(front_r);
      out_tail_light    <= brake ? rcd_pkg::LEVEL_HIGH :
                           ((front_r != 2'd0) ? rcd_pkg::LEVEL_LOW : 9'd0);
      out_aux_light     <= rcd_pkg::intensity(aux_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign stat.need_div  = need_div;
  assign stat.div_last  = cnt_r == 5'(rcd_pkg::DIV_STEPS - 1);
  assign stat.out_hold  = out_valid_r && !out_ready;

endmodule

@@ design/rc_vehicle_drive_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_vehicle_drive_controller
// One control tick of a gamepad-driven RC car: lights, gear, steering, motor.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake              | Word
//  in_ch    | sink      | valid/ready            | gamepad tick + steering sample
//  out_ch   | source    | valid/ready            | servo, motor and light levels
//  cfg      | slave     | APB psel/penable/pready| steer mode, calibrated positions
//
// A word passes the evaluate and interpolation multiply steps and is loaded into
// the output register in the emit step; the next word is taken only once the
// sequencer is back in idle. In feedback mode with an interpolated target and a
// positive range, the 25-step restoring divider that forms the interpolation weight runs first.
// rst_n is synchronous: lights off, gear 1, counter 0, registers to defaults.
// A finished word waits in the output register; the next word is accepted
// meanwhile and holds in the emit step only if the previous one is still there.
// ----------------------------------------------------------------------------
`include "rc_vehicle_drive_controller_defines.svh"

module rc_vehicle_drive_controller (
  input  logic        clk,
  input  logic        rst_n,
  rcd_in_if.sink      in_ch,
  rcd_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rcd_pkg::cfg_t  cfg_r;
  rcd_pkg::cmd_t  cmd;
  rcd_pkg::stat_t stat;
  logic           cfg_wr;

  // Register file: write on the access phase, index by word address.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steer_mode      <= rcd_pkg::RST_STEER_MODE;
      cfg_r.center_position <= rcd_pkg::RST_CENTER;
      cfg_r.left_position   <= rcd_pkg::RST_LEFT;
      cfg_r.right_position  <= rcd_pkg::RST_RIGHT;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rcd_pkg::REG_STEER_MODE: cfg_r.steer_mode      <= pwdata[1:0];
        rcd_pkg::REG_CENTER:     cfg_r.center_position <= pwdata[11:0];
        rcd_pkg::REG_LEFT:       cfg_r.left_position   <= pwdata[11:0];
        rcd_pkg::REG_RIGHT:      cfg_r.right_position  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    case (paddr[3:2])
      rcd_pkg::REG_STEER_MODE: prdata = {30'd0, cfg_r.steer_mode};
      rcd_pkg::REG_CENTER:     prdata = {20'd0, cfg_r.center_position};
      rcd_pkg::REG_LEFT:       prdata = {20'd0, cfg_r.left_position};
      rcd_pkg::REG_RIGHT:      prdata = {20'd0, cfg_r.right_position};
      default:                 prdata = '0;
    endcase
  end

  // Sequencer: accept in idle, then advance through evaluate/divide/multiply/emit.
  rcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: holds vehicle state and the output register.
  rcd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd                 (cmd),
    .stat                (stat),
    .in_buttons_held     (in_ch.buttons_held),
    .in_buttons_changed  (in_ch.buttons_changed),
    .in_hat_direction    (in_ch.hat_direction),
    .in_stick_x          (in_ch.stick_x),
    .in_brake_trigger    (in_ch.brake_trigger),
    .in_throttle_trigger (in_ch.throttle_trigger),
    .in_feedback_sample  (in_ch.feedback_sample),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_servo_level_a   (out_ch.servo_level_a),
    .out_servo_level_b   (out_ch.servo_level_b),
    .out_servo_drive     (out_ch.servo_drive),
    .out_motor_forward   (out_ch.motor_forward),
    .out_motor_reverse   (out_ch.motor_reverse),
    .out_front_light     (out_ch.front_light),
    .out_tail_light      (out_ch.tail_light),
    .out_aux_light       (out_ch.aux_light)
  );

  // An accepted word blocks the input until its result is emitted.
  `RCD_ASSERT_NEXT(a_accept_blocks, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // A fresh result appears only as the sequencer returns to idle.
  `RCD_ASSERT_IMPL(a_emit_idle, clk, rst_n, $rose(out_ch.valid), in_ch.ready)
  // The last divider step hands over to the interpolation multiply.
  `RCD_ASSERT_NEXT(a_div_to_mul, clk, rst_n, cmd.div_step && stat.div_last, cmd.mul)
  // At most one datapath command per cycle.
  `RCD_ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n, $onehot0(cmd))

endmodule
